[rtl/core/jsfe_pkg.sv]
// jsfe_pkg: phase codes, result kinds, character constants and the step
// result type for the json string field extractor
// no dependencies
package jsfe_pkg;

    // phase codes: key search with 0..4 characters matched, then the value states
    localparam logic [3:0] PH_KEY0      = 4'd0;
    localparam logic [3:0] PH_KEY4      = 4'd4;
    localparam logic [3:0] PH_WS_COLON  = 4'd5;
    localparam logic [3:0] PH_WS_QUOTE  = 4'd6;
    localparam logic [3:0] PH_VALUE     = 4'd7;
    localparam logic [3:0] PH_ESCAPE    = 4'd8;
    localparam logic [3:0] PH_DONE      = 4'd9;
    localparam logic [3:0] PH_KEY1      = 4'd1;

    // result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;

    // outcome of one byte
    typedef struct packed {
        logic       emit;
        logic [1:0] kind;
        logic [7:0] value_char;
    } t_step_res;

    // quoted key text, one character per matched count
    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] c;
        c = CH_QUOTE;
        case (idx)
            3'd1:    c = CH_S;
            3'd2:    c = CH_Q;
            3'd3:    c = CH_L;
            default: c = CH_QUOTE;
        endcase
        return c;
    endfunction

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

[rtl/core/jsfe_step.sv]
// jsfe_step: next phase and result for one body byte
// depends on jsfe_pkg
module jsfe_step (
    input  logic [3:0]         i_phase,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output logic [3:0]         o_phase,
    output jsfe_pkg::t_step_res o_res
);
    import jsfe_pkg::*;

    logic       active;
    logic       ev_emit;
    logic [1:0] ev_kind;
    logic [7:0] ev_char;
    logic [3:0] ph_next;

    assign active = (i_phase < PH_DONE);

    // per-phase decode of the byte
    always_comb begin
        ev_emit = 1'b0;
        ev_kind = KIND_CHAR;
        ev_char = CH_NUL;
        ph_next = i_phase;
        if (active && (i_byte == CH_NUL)) begin
            ev_emit = 1'b1;
            ev_kind = KIND_FAIL;
            ph_next = PH_DONE;
        end else begin
            unique case (i_phase) inside
                [PH_KEY0:PH_KEY4]: begin
                    if (i_byte == key_char(i_phase[2:0])) begin
                        ph_next = i_phase + 4'd1;
                    end else if (i_byte == CH_QUOTE) begin
                        ph_next = PH_KEY1;
                    end else begin
                        ph_next = PH_KEY0;
                    end
                end
                PH_WS_COLON: begin
                    if (is_white(i_byte)) begin
                        ph_next = PH_WS_COLON;
                    end else if (i_byte == CH_COLON) begin
                        ph_next = PH_WS_QUOTE;
                    end else begin
                        ev_emit = 1'b1;
                        ev_kind = KIND_FAIL;
                        ph_next = PH_DONE;
                    end
                end
                PH_WS_QUOTE: begin
                    if (is_white(i_byte)) begin
                        ph_next = PH_WS_QUOTE;
                    end else if (i_byte == CH_QUOTE) begin
                        ph_next = PH_VALUE;
                    end else begin
                        ev_emit = 1'b1;
                        ev_kind = KIND_FAIL;
                        ph_next = PH_DONE;
                    end
                end
                PH_VALUE: begin
                    if (i_byte == CH_QUOTE) begin
                        ev_emit = 1'b1;
                        ev_kind = KIND_OK;
                        ph_next = PH_DONE;
                    end else if (i_byte == CH_BSL) begin
                        ph_next = PH_ESCAPE;
                    end else begin
                        ev_emit = 1'b1;
                        ev_char = i_byte;
                    end
                end
                PH_ESCAPE: begin
                    ev_emit = 1'b1;
                    ph_next = PH_VALUE;
                    case (i_byte)
                        CH_QUOTE, CH_BSL, CH_SLASH: ev_char = i_byte;
                        CH_N:    ev_char = CH_LF;
                        CH_R:    ev_char = CH_CR;
                        CH_T:    ev_char = CH_TAB;
                        default: begin
                            ev_kind = KIND_FAIL;
                            ph_next = PH_DONE;
                        end
                    endcase
                end
                default: ph_next = i_phase;
            endcase
        end
    end

    // last byte: an unfinished extraction fails, and the search rearms
    always_comb begin
        o_res.emit       = ev_emit;
        o_res.kind       = ev_kind;
        o_res.value_char = ev_char;
        o_phase          = ph_next;
        if (i_last) begin
            o_phase = PH_KEY0;
            if (active && (!ev_emit || (ev_kind == KIND_CHAR))) begin
                o_res.emit = 1'b1;
                o_res.kind = KIND_FAIL;
            end
        end
        if (o_res.kind != KIND_CHAR) begin
            o_res.value_char = CH_NUL;
        end
    end

endmodule

[rtl/core/json_string_field_extractor.sv]
// json_string_field_extractor: top level, input register, phase register and
// result register around the per-byte step logic
// depends on jsfe_pkg and jsfe_step
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  body in | i_in_valid, o_in_ready, i_body_byte,           | in
//          | i_end_of_message                               |
//  result  | o_out_valid, i_out_ready, o_kind, o_value_char | out
//
// one byte per cycle while results are taken; each result passes from the
// input register through the step logic into the result register
// the phase register moves as a byte leaves the input register; the single
// step stage lies between the input and result registers
// synchronous active-low reset clears valids and returns to key search
// a stalled result holds the input register; a byte with no result drains
// only when the result register can take a new request
module json_string_field_extractor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_body_byte,
    input  logic       i_end_of_message,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_value_char
);
    import jsfe_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic [3:0] r_phase;
    logic [3:0] n_phase;
    logic       r_out_valid;
    logic [1:0] r_kind;
    logic [7:0] r_char;
    logic       step_fire;
    t_step_res  step_res;

    // byte moves on when the result slot is free or being emptied
    assign step_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step_fire;

    jsfe_step u_step (
        .i_phase (r_phase),
        .i_byte  (r_byte),
        .i_last  (r_last),
        .o_phase (n_phase),
        .o_res   (step_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_body_byte;
            r_last <= i_end_of_message;
        end
    end

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_KEY0;
        end else if (step_fire) begin
            r_phase <= n_phase;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire) begin
            r_out_valid <= step_res.emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (step_fire && step_res.emit) begin
            r_kind <= step_res.kind;
            r_char <= step_res.value_char;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_value_char = r_char;

endmodule
